// ----- rtl/ymodem_frame_receiver_unit_macros.svh -----
// Assertion macros shared by the checker of the YMODEM frame receiver.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef YMODEM_FRAME_RECEIVER_UNIT_MACROS_SVH
`define YMODEM_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define YFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("yfr assertion failed");

// next-cycle implication, disabled during reset
`define YFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("yfr assertion failed");

`endif

// ----- rtl/yfr_pkg.sv -----
// Types and constants of the YMODEM frame receiver.
// Used by the byte CRC unit, the top level and the checker.
package yfr_pkg;

    localparam int SHORT_PAYLOAD = 128;
    localparam int LONG_PAYLOAD  = 1024;

    localparam logic [10:0] SHORT_CRC_HI_POS = 11'(SHORT_PAYLOAD + 3);
    localparam logic [10:0] LONG_CRC_HI_POS  = 11'(LONG_PAYLOAD + 3);
    localparam logic [10:0] SHORT_FRAME_LEN  = 11'(SHORT_PAYLOAD + 5);
    localparam logic [10:0] LONG_FRAME_LEN   = 11'(LONG_PAYLOAD + 5);

    localparam logic [10:0] POS_BLOCK   = 11'd1;
    localparam logic [10:0] POS_INVERSE = 11'd2;
    localparam logic [10:0] POS_PAYLOAD = 11'd3;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_REQ = 8'h43;

    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_GOOD    = 3'd2,
        EV_BAD     = 3'd3,
        EV_END     = 3'd4,
        EV_ABORT   = 3'd5,
        EV_CRC_REQ = 3'd6
    } t_event;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_req;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  block_number;
        logic [10:0] frame_length;
    } t_out_res;

endpackage

// ----- rtl/ymodem_frame_receiver_unit.sv -----
// YMODEM block deframer with CRC-16/XMODEM check.
// Depends on yfr_pkg and yfr_crc_byte.
//
// Input channel: i_in_valid / o_in_stall carry one request of t_in_req, a
// received byte (mode 0) or a restart of the expected block number (mode 1).
// Output channel: o_out_valid / i_out_stall carry one t_out_res
// per request: an event code with payload byte, block number and frame length.
// Every request gives exactly one result, in order.
// Throughput: one request per cycle while the output is not stalled; the CRC
// of a payload byte is folded combinationally by an unrolled eight-step
// network, which sets the clock path.
// A request is held in the input register; a result waits in the result
// register while the input register still takes one more request, so the
// input stalls only when both are full and the output is stalled.
// Reset (synchronous, active low) empties both registers, returns to the
// header phase and clears the expected block number.
module ymodem_frame_receiver_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  yfr_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output yfr_pkg::t_out_res o_out_data
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SHORT  = 2'd1,
        PH_LONG   = 2'd2
    } t_phase;

    logic              r_in_valid;
    yfr_pkg::t_in_req  r_in;
    logic              r_out_valid;
    yfr_pkg::t_out_res r_out;

    t_phase      r_phase,    n_phase;
    logic [10:0] r_count,    n_count;
    logic [7:0]  r_exp_seq,  n_exp_seq;
    logic [7:0]  r_got_seq,  n_got_seq;
    logic [7:0]  r_got_inv,  n_got_inv;
    logic [15:0] r_crc,      n_crc;
    logic [7:0]  r_crc_hi,   n_crc_hi;
    yfr_pkg::t_out_res n_out;

    logic        move;
    logic        accept;
    logic [15:0] crc_folded;
    logic [10:0] crc_hi_pos;
    logic [10:0] frame_len;
    logic        good;

    assign move       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;
    assign accept     = i_in_valid && !o_in_stall;

    yfr_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_data (r_in.rx_byte),
        .o_crc  (crc_folded)
    );

    assign crc_hi_pos = (r_phase == PH_SHORT) ? yfr_pkg::SHORT_CRC_HI_POS
                                              : yfr_pkg::LONG_CRC_HI_POS;
    assign frame_len  = (r_phase == PH_SHORT) ? yfr_pkg::SHORT_FRAME_LEN
                                              : yfr_pkg::LONG_FRAME_LEN;
    assign good = (r_got_seq == r_exp_seq) && (r_got_seq == ~r_got_inv)
               && ({r_crc_hi, r_in.rx_byte} == r_crc);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_exp_seq = r_exp_seq;
        n_got_seq = r_got_seq;
        n_got_inv = r_got_inv;
        n_crc     = r_crc;
        n_crc_hi  = r_crc_hi;
        n_out     = '{event_res: yfr_pkg::EV_NONE, payload_byte: 8'd0,
                      block_number: 8'd0, frame_length: 11'd0};
        if (r_in.mode == yfr_pkg::MODE_RESTART) begin
            n_exp_seq = 8'd0;
        end else if (r_phase == PH_SHORT || r_phase == PH_LONG) begin
            n_count = r_count + 11'd1;
            priority if (r_count == yfr_pkg::POS_BLOCK) begin
                n_got_seq = r_in.rx_byte;
            end else if (r_count == yfr_pkg::POS_INVERSE) begin
                n_got_inv = r_in.rx_byte;
            end else if (r_count >= yfr_pkg::POS_PAYLOAD && r_count < crc_hi_pos) begin
                n_crc                = crc_folded;
                n_out.event_res      = yfr_pkg::EV_PAYLOAD;
                n_out.payload_byte   = r_in.rx_byte;
            end else if (r_count == crc_hi_pos) begin
                n_crc_hi = r_in.rx_byte;
            end else begin
                if (good) begin
                    n_exp_seq = r_exp_seq + 8'd1;
                end
                n_out.event_res    = good ? yfr_pkg::EV_GOOD : yfr_pkg::EV_BAD;
                n_out.block_number = r_got_seq;
                n_out.frame_length = frame_len;
                n_phase            = PH_HEADER;
                n_count            = 11'd0;
            end
        end else begin
            n_phase = PH_HEADER;
            n_count = 11'd0;
            priority if (r_in.rx_byte == yfr_pkg::BYTE_SOH) begin
                n_phase = PH_SHORT;
                n_count = 11'd1;
                n_crc   = 16'd0;
            end else if (r_in.rx_byte == yfr_pkg::BYTE_STX) begin
                n_phase = PH_LONG;
                n_count = 11'd1;
                n_crc   = 16'd0;
            end else if (r_in.rx_byte == yfr_pkg::BYTE_EOT) begin
                n_out.event_res = yfr_pkg::EV_END;
            end else if (r_in.rx_byte == yfr_pkg::BYTE_REQ) begin
                n_out.event_res = yfr_pkg::EV_CRC_REQ;
            end else begin
                n_out.event_res = yfr_pkg::EV_ABORT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HEADER;
            r_count     <= 11'd0;
            r_exp_seq   <= 8'd0;
            r_got_seq   <= 8'd0;
            r_got_inv   <= 8'd0;
            r_crc       <= 16'd0;
            r_crc_hi    <= 8'd0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_exp_seq   <= n_exp_seq;
                r_got_seq   <= n_got_seq;
                r_got_inv   <= n_got_inv;
                r_crc       <= n_crc;
                r_crc_hi    <= n_crc_hi;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/yfr_crc_byte.sv -----
// Folds one byte into a CRC-16/XMODEM value, eight bit steps unrolled.
// Depends on yfr_pkg for the polynomial.
module yfr_crc_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ yfr_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

// ----- rtl/yfr_checker.sv -----
// Port-level checker of the YMODEM frame receiver, bound to the top level.
// Depends on yfr_pkg and ymodem_frame_receiver_unit_macros.svh.
`include "ymodem_frame_receiver_unit_macros.svh"

module yfr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input yfr_pkg::t_in_req  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input yfr_pkg::t_out_res o_out_data
);

    `YFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `YFR_ASSERT_NOW(a_payload_fields, i_clk, i_rst_n, o_out_valid && o_out_data.event_res == yfr_pkg::EV_PAYLOAD, o_out_data.block_number == 8'd0 && o_out_data.frame_length == 11'd0)
    `YFR_ASSERT_NOW(a_frame_length, i_clk, i_rst_n, o_out_valid && (o_out_data.event_res == yfr_pkg::EV_GOOD || o_out_data.event_res == yfr_pkg::EV_BAD), o_out_data.frame_length == yfr_pkg::SHORT_FRAME_LEN || o_out_data.frame_length == yfr_pkg::LONG_FRAME_LEN)
    `YFR_ASSERT_NOW(a_byte_only_payload, i_clk, i_rst_n, o_out_valid && o_out_data.event_res != yfr_pkg::EV_PAYLOAD, o_out_data.payload_byte == 8'd0)

endmodule

bind ymodem_frame_receiver_unit yfr_checker u_yfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- tb/tb_ymodem_frame_receiver_unit.sv -----
// Self-checking testbench of the YMODEM frame receiver: frames, header events and restarts
// are driven under random idling on both channels and checked against an in-order predictor.
// Depends on yfr_pkg and ymodem_frame_receiver_unit.
module tb_ymodem_frame_receiver_unit;
    import yfr_pkg::*;

    localparam logic [7:0] BYTE_CAN = 8'h18;
    localparam int unsigned TOTAL_ITEMS = 1900;

    typedef enum logic [1:0] {
        HUNT_HEADER = 2'd0,
        IN_SHORT    = 2'd1,
        IN_LONG     = 2'd2
    } t_phase;

    typedef enum int {
        DMG_NONE,
        DMG_SEQ,
        DMG_INV,
        DMG_CRC,
        DMG_RESTART,
        DMG_TRUNC
    } t_damage;

    class frame_scoreboard;
        t_out_res    expected_q[$];
        int unsigned errors;
        t_phase      phase;
        logic [10:0] byte_count;
        logic [7:0]  expected_seq;
        logic [7:0]  got_seq;
        logic [7:0]  got_inverse;
        logic [15:0] running_crc;
        logic [7:0]  crc_high;

        function new();
            errors       = 0;
            phase        = HUNT_HEADER;
            byte_count   = '0;
            expected_seq = '0;
            got_seq      = '0;
            got_inverse  = '0;
            running_crc  = '0;
            crc_high     = '0;
        endfunction

        function logic [15:0] fold_crc(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) begin
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            return c;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_request(t_in_req req);
            t_out_res    res;
            logic [10:0] plen;
            logic        frame_ok;
            res           = '0;
            res.event_res = EV_NONE;
            if (req.mode == MODE_RESTART) begin
                expected_seq = '0;
            end else if (phase != HUNT_HEADER) begin
                plen = (phase == IN_SHORT) ? 11'(SHORT_PAYLOAD) : 11'(LONG_PAYLOAD);
                if (byte_count == POS_BLOCK) begin
                    got_seq = req.rx_byte;
                end else if (byte_count == POS_INVERSE) begin
                    got_inverse = req.rx_byte;
                end else if (byte_count < plen + 11'd3) begin
                    running_crc      = fold_crc(running_crc, req.rx_byte);
                    res.event_res    = EV_PAYLOAD;
                    res.payload_byte = req.rx_byte;
                end else if (byte_count == plen + 11'd3) begin
                    crc_high = req.rx_byte;
                end else begin
                    frame_ok = (got_seq == expected_seq) && (got_seq == ~got_inverse)
                               && ({crc_high, req.rx_byte} == running_crc);
                    if (frame_ok) begin
                        expected_seq = expected_seq + 8'd1;
                    end
                    res.event_res    = frame_ok ? EV_GOOD : EV_BAD;
                    res.block_number = got_seq;
                    res.frame_length = plen + 11'd5;
                    phase            = HUNT_HEADER;
                    byte_count       = '0;
                end
                if (phase != HUNT_HEADER) begin
                    byte_count = byte_count + 11'd1;
                end
            end else begin
                byte_count = '0;
                case (req.rx_byte)
                    BYTE_SOH, BYTE_STX: begin
                        phase       = (req.rx_byte == BYTE_SOH) ? IN_SHORT : IN_LONG;
                        byte_count  = 11'd1;
                        running_crc = '0;
                    end
                    BYTE_EOT: res.event_res = EV_END;
                    BYTE_REQ: res.event_res = EV_CRC_REQ;
                    default:  res.event_res = EV_ABORT;
                endcase
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;
            if (expected_q.size() == 0) begin
                $error("result with nothing outstanding: event_res %0d", got.event_res);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.event_res !== want.event_res) begin
                $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
                errors++;
            end
            if (got.payload_byte !== want.payload_byte) begin
                $error("payload_byte: expected %0d, actual %0d",
                       want.payload_byte, got.payload_byte);
                errors++;
            end
            if (got.block_number !== want.block_number) begin
                $error("block_number: expected %0d, actual %0d",
                       want.block_number, got.block_number);
                errors++;
            end
            if (got.frame_length !== want.frame_length) begin
                $error("frame_length: expected %0d, actual %0d",
                       want.frame_length, got.frame_length);
                errors++;
            end
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_res o_out_data;

    frame_scoreboard sb = new();
    int unsigned     items_sent   = 0;
    int unsigned     in_idle_pct  = 0;
    int unsigned     out_idle_pct = 0;

    ymodem_frame_receiver_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_idle_pct != 0 && $urandom_range(1, 100) <= out_idle_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned pick_idle();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 25;
        endcase
    endfunction

    task automatic send_request(input t_in_req req);
        if (in_idle_pct != 0 && $urandom_range(1, 100) <= in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_frame(input bit long_frame, input t_damage damage, input bit extremes);
        logic [7:0]  frame_q[$];
        logic [7:0]  seq;
        logic [7:0]  b;
        logic [15:0] crc;
        int unsigned plen;
        int unsigned stop_at;
        int unsigned restart_at;
        plen = long_frame ? LONG_PAYLOAD : SHORT_PAYLOAD;
        seq  = sb.expected_seq;
        if (damage == DMG_SEQ) begin
            seq = extremes ? ~seq : seq + 8'($urandom_range(1, 255));
        end
        crc = '0;
        frame_q.push_back(long_frame ? BYTE_STX : BYTE_SOH);
        frame_q.push_back(seq);
        frame_q.push_back(damage == DMG_INV ? (~seq) ^ 8'($urandom_range(1, 255)) : ~seq);
        for (int i = 0; i < plen; i++) begin
            b = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
            crc = sb.fold_crc(crc, b);
            frame_q.push_back(b);
        end
        if (damage == DMG_CRC) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(crc[7:0]);
        stop_at    = (damage == DMG_TRUNC) ? $urandom_range(1, frame_q.size() - 1)
                                           : frame_q.size();
        restart_at = (damage == DMG_RESTART) ? $urandom_range(1, frame_q.size() - 1)
                                             : frame_q.size();
        for (int i = 0; i < stop_at; i++) begin
            if (i == restart_at) begin
                send_request(t_in_req'{MODE_RESTART, 8'($urandom)});
            end
            send_request(t_in_req'{MODE_BYTE, frame_q[i]});
        end
    endtask

    initial begin
        int unsigned last_drain;
        int unsigned r;
        t_damage     damage;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        in_idle_pct  = 10;
        out_idle_pct = 10;
        send_request(t_in_req'{MODE_RESTART, 8'h00});
        send_request(t_in_req'{MODE_BYTE, BYTE_EOT});
        send_request(t_in_req'{MODE_BYTE, BYTE_CAN});
        send_request(t_in_req'{MODE_BYTE, BYTE_REQ});
        send_request(t_in_req'{MODE_BYTE, 8'h00});
        send_request(t_in_req'{MODE_BYTE, 8'hFF});
        send_request(t_in_req'{MODE_BYTE, 8'h03});
        send_request(t_in_req'{MODE_RESTART, 8'hFF});
        send_frame(1'b0, DMG_SEQ, 1'b1);
        send_frame(1'b0, DMG_NONE, 1'b1);
        send_frame(1'b0, DMG_CRC, 1'b0);
        send_frame(1'b0, DMG_INV, 1'b0);
        send_frame(1'b0, DMG_RESTART, 1'b0);
        send_frame(1'b1, DMG_NONE, 1'b0);
        wait_drained();

        last_drain = items_sent;
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent + 150 >= TOTAL_ITEMS) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else if ($urandom_range(0, 7) == 0) begin
                in_idle_pct  = pick_idle();
                out_idle_pct = pick_idle();
            end
            if (items_sent - last_drain >= 500) begin
                wait_drained();
                last_drain = items_sent;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                r = $urandom_range(0, 99);
                damage = r < 60 ? DMG_NONE : r < 70 ? DMG_SEQ : r < 78 ? DMG_INV :
                         r < 88 ? DMG_CRC : r < 94 ? DMG_RESTART : DMG_TRUNC;
                send_frame(1'b0, damage, 1'b0);
            end else begin
                case ($urandom_range(0, 4))
                    0:       send_request(t_in_req'{MODE_BYTE, BYTE_EOT});
                    1:       send_request(t_in_req'{MODE_BYTE, BYTE_CAN});
                    2:       send_request(t_in_req'{MODE_BYTE, BYTE_REQ});
                    3:       send_request(t_in_req'{MODE_RESTART, 8'($urandom)});
                    default: send_request(t_in_req'{MODE_BYTE, 8'($urandom)});
                endcase
            end
        end

        in_idle_pct  = 0;
        out_idle_pct = 0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
